>>> rtl/core/blprc_pkg.sv
// shared types, constants and the control program of the buffer level pi rate controller
// no dependencies; used by every other file of the block
package blprc_pkg;

	localparam int IN_W               = 16;
	localparam int COUNT_BITS_DEFAULT = 16;
	localparam int ERR_W              = 18;
	localparam int MUL_A_W            = ERR_W;
	localparam int MUL_B_W            = 20;
	localparam int PROD_W             = MUL_A_W + MUL_B_W + 1;
	localparam int ISUM_W             = PROD_W + 1;
	localparam int INTEG_W            = 33;
	localparam int PRAW_W             = 24;
	localparam int CFG_IDX_W          = 3;
	localparam int CFG_DATA_W         = 20;
	localparam int STEP_W             = 4;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_P_GAIN         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_I_GAIN         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ADJUST_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_P_TERM_LIMIT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd6;

	localparam logic [16:0] RST_TARGET_LEVEL   = 17'd4096;
	localparam logic [16:0] RST_SMOOTHING      = 17'd6554;
	localparam logic [15:0] RST_P_GAIN         = 16'd256;
	localparam logic [19:0] RST_I_GAIN         = 20'd655;
	localparam logic [14:0] RST_ADJUST_LIMIT   = 15'd1000;
	localparam logic [14:0] RST_P_TERM_LIMIT   = 15'd500;
	localparam logic [14:0] RST_INTEGRAL_LIMIT = 15'd500;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t S_IDLE    = 4'd0;
	localparam step_t S_MUL_NEW = 4'd1;
	localparam step_t S_ACC_HI  = 4'd2;
	localparam step_t S_ACC_LO  = 4'd3;
	localparam step_t S_AVG     = 4'd4;
	localparam step_t S_ERR     = 4'd5;
	localparam step_t S_ECLAMP  = 4'd6;
	localparam step_t S_ISUM    = 4'd7;
	localparam step_t S_ICLAMP  = 4'd8;
	localparam step_t S_PCLAMP  = 4'd9;
	localparam step_t S_OSUM    = 4'd10;
	localparam step_t S_EMIT    = 4'd11;
	localparam step_t S_FIRST   = 4'd12;

	typedef enum logic [2:0] {
		MA_LEVEL,
		MA_AVG_HI,
		MA_AVG_LO,
		MA_ERR,
		MA_E
	} mul_a_t;

	typedef enum logic [1:0] {
		MB_ALPHA,
		MB_BETA,
		MB_IGAIN,
		MB_PGAIN
	} mul_b_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_FIRST,
		OP_ACC_SET,
		OP_ACC_ADD,
		OP_AVG_FIN,
		OP_ERR,
		OP_ECLAMP,
		OP_ISUM,
		OP_ICLAMP,
		OP_PCLAMP,
		OP_OSUM,
		OP_EMIT
	} dp_op_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_IN,
		COND_LOADED_N,
		COND_JUMP,
		COND_OUT
	} cond_t;

	typedef struct packed {
		mul_a_t mul_a;
		mul_b_t mul_b;
		dp_op_t op;
		cond_t  cond;
		step_t  target;
	} ctl_word_t;

	typedef struct packed {
		mul_a_t mul_a;
		mul_b_t mul_b;
		dp_op_t op;
	} dp_ctl_t;

	typedef struct packed {
		logic loaded;
	} dp_status_t;

	typedef struct packed {
		logic [16:0] target_level;
		logic [16:0] smoothing_alpha;
		logic [15:0] p_gain;
		logic [19:0] i_gain;
		logic [14:0] adjust_limit;
		logic [14:0] p_term_limit;
		logic [14:0] integral_limit;
	} cfg_t;

	function automatic ctl_word_t ucode(step_t s);
		ctl_word_t w;
		case (s)
			S_IDLE:    w = '{mul_a: MA_LEVEL,  mul_b: MB_ALPHA, op: OP_LOAD,
			                 cond: COND_IN,       target: S_IDLE};
			S_MUL_NEW: w = '{mul_a: MA_LEVEL,  mul_b: MB_ALPHA, op: OP_NOP,
			                 cond: COND_LOADED_N, target: S_FIRST};
			S_ACC_HI:  w = '{mul_a: MA_AVG_HI, mul_b: MB_BETA,  op: OP_ACC_SET,
			                 cond: COND_NEXT,     target: S_IDLE};
			S_ACC_LO:  w = '{mul_a: MA_AVG_LO, mul_b: MB_BETA,  op: OP_ACC_ADD,
			                 cond: COND_NEXT,     target: S_IDLE};
			S_AVG:     w = '{mul_a: MA_LEVEL,  mul_b: MB_ALPHA, op: OP_AVG_FIN,
			                 cond: COND_NEXT,     target: S_IDLE};
			S_ERR:     w = '{mul_a: MA_LEVEL,  mul_b: MB_ALPHA, op: OP_ERR,
			                 cond: COND_NEXT,     target: S_IDLE};
			S_ECLAMP:  w = '{mul_a: MA_ERR,    mul_b: MB_IGAIN, op: OP_ECLAMP,
			                 cond: COND_NEXT,     target: S_IDLE};
			S_ISUM:    w = '{mul_a: MA_E,      mul_b: MB_PGAIN, op: OP_ISUM,
			                 cond: COND_NEXT,     target: S_IDLE};
			S_ICLAMP:  w = '{mul_a: MA_LEVEL,  mul_b: MB_ALPHA, op: OP_ICLAMP,
			                 cond: COND_NEXT,     target: S_IDLE};
			S_PCLAMP:  w = '{mul_a: MA_LEVEL,  mul_b: MB_ALPHA, op: OP_PCLAMP,
			                 cond: COND_NEXT,     target: S_IDLE};
			S_OSUM:    w = '{mul_a: MA_LEVEL,  mul_b: MB_ALPHA, op: OP_OSUM,
			                 cond: COND_NEXT,     target: S_IDLE};
			S_EMIT:    w = '{mul_a: MA_LEVEL,  mul_b: MB_ALPHA, op: OP_EMIT,
			                 cond: COND_OUT,      target: S_IDLE};
			S_FIRST:   w = '{mul_a: MA_LEVEL,  mul_b: MB_ALPHA, op: OP_FIRST,
			                 cond: COND_JUMP,     target: S_ERR};
			default:   w = '{mul_a: MA_LEVEL,  mul_b: MB_ALPHA, op: OP_NOP,
			                 cond: COND_JUMP,     target: S_IDLE};
		endcase
		return w;
	endfunction

endpackage

>>> rtl/core/blprc_sequencer.sv
// step counter and control rom of the rate controller, with the input and output handshakes
// depends on blprc_pkg for the control word, conditions and the program
module blprc_sequencer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  blprc_pkg::dp_status_t  status,
	output blprc_pkg::dp_ctl_t     ctl
);
	import blprc_pkg::*;

	step_t     step_q;
	step_t     step_d;
	logic      out_valid_q;
	logic      fire;
	ctl_word_t w;

	assign w         = ucode(step_q);
	assign in_ready  = (w.cond == COND_IN);
	assign out_valid = out_valid_q;

	always_comb begin
		case (w.cond)
			COND_IN:  fire = in_valid;
			COND_OUT: fire = !out_valid_q || out_ready;
			default:  fire = 1'b1;
		endcase
	end

	always_comb begin
		step_d = step_q;
		if (fire) begin
			case (w.cond)
				COND_LOADED_N: step_d = status.loaded ? step_q + 4'd1 : w.target;
				COND_JUMP:     step_d = w.target;
				COND_OUT:      step_d = w.target;
				default:       step_d = step_q + 4'd1;
			endcase
		end
	end

	assign ctl.mul_a = w.mul_a;
	assign ctl.mul_b = w.mul_b;
	assign ctl.op    = fire ? w.op : OP_NOP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (fire && w.cond == COND_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/blprc_datapath.sv
// datapath of the rate controller: shared multiplier, moving average, pi terms, output word
// depends on blprc_pkg; blprc_sequencer drives one op per cycle, none in handshake stalls
module blprc_datapath #(
	parameter int COUNT_BITS = blprc_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  blprc_pkg::dp_ctl_t                ctl,
	output blprc_pkg::dp_status_t             status,
	input  blprc_pkg::cfg_t                   cfg,
	input  logic [blprc_pkg::IN_W-1:0]        fifo_count,
	input  logic [blprc_pkg::IN_W-1:0]        pend_count,
	output logic signed [15:0]                rate_adjust,
	output logic [16:0]                       smoothed_level,
	output logic signed [blprc_pkg::ERR_W-1:0] level_error
);
	import blprc_pkg::*;

	localparam int CNT_W   = (COUNT_BITS < IN_W) ? COUNT_BITS : IN_W;
	localparam int LEVEL_W = CNT_W + 1;
	localparam int AVG_W   = LEVEL_W + 16;

	logic [LEVEL_W-1:0]        level_q;
	logic [AVG_W-1:0]          avg_q;
	logic                      loaded_q;
	logic [AVG_W-1:0]          acc_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [15:0]        e_q;
	logic signed [ISUM_W-1:0]  isum_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [PRAW_W-1:0]  praw_q;
	logic signed [15:0]        p_q;
	logic signed [16:0]        itr_q;
	logic signed [17:0]        osum_q;
	logic signed [15:0]        rate_adjust_q;
	logic [16:0]               smoothed_q;
	logic signed [ERR_W-1:0]   level_error_q;

	logic [16:0]               alpha_eff;
	logic [16:0]               beta;
	logic signed [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	logic signed [PROD_W-1:0]  prod_d;
	logic [LEVEL_W-1:0]        floored;
	logic signed [ERR_W-1:0]   err_d;
	logic signed [ERR_W-1:0]   adj_e;
	logic signed [15:0]        e_d;
	logic signed [ISUM_W-1:0]  ilim_pos;
	logic signed [INTEG_W-1:0] integ_clamped;
	logic signed [PROD_W-1:0]  pbias;
	logic signed [PROD_W-1:0]  pshift;
	logic signed [PRAW_W-1:0]  ptl;
	logic signed [15:0]        p_d;
	logic signed [INTEG_W-1:0] ibias;
	logic signed [INTEG_W-1:0] ishift;
	logic signed [17:0]        lim_o;
	logic signed [17:0]        outv;
	logic                      sat_hi;
	logic                      sat_lo;
	logic signed [16:0]        windup;

	assign alpha_eff = (cfg.smoothing_alpha > ONE_Q16) ? ONE_Q16 : cfg.smoothing_alpha;
	assign beta      = ONE_Q16 - alpha_eff;
	assign floored   = avg_q[AVG_W-1:16];

	always_comb begin
		case (ctl.mul_a)
			MA_LEVEL:  mul_a = $signed(MUL_A_W'(level_q));
			MA_AVG_HI: mul_a = $signed(MUL_A_W'(floored));
			MA_AVG_LO: mul_a = $signed(MUL_A_W'(avg_q[15:0]));
			MA_ERR:    mul_a = err_q;
			MA_E:      mul_a = MUL_A_W'(e_q);
			default:   mul_a = '0;
		endcase
		case (ctl.mul_b)
			MB_ALPHA: mul_b = MUL_B_W'(alpha_eff);
			MB_BETA:  mul_b = MUL_B_W'(beta);
			MB_IGAIN: mul_b = cfg.i_gain;
			MB_PGAIN: mul_b = MUL_B_W'(cfg.p_gain);
			default:  mul_b = '0;
		endcase
	end

	assign prod_d = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));

	always_comb begin
		err_d = $signed(ERR_W'(cfg.target_level)) - $signed(ERR_W'(floored));

		// error clamped to the adjust limit
		adj_e = $signed(ERR_W'(cfg.adjust_limit));
		if (err_q > adj_e) begin
			e_d = adj_e[15:0];
		end else if (err_q < -adj_e) begin
			e_d = 16'(-adj_e);
		end else begin
			e_d = err_q[15:0];
		end

		ilim_pos = $signed(ISUM_W'({cfg.integral_limit, 16'b0}));
		if (isum_q > ilim_pos) begin
			integ_clamped = ilim_pos[INTEG_W-1:0];
		end else if (isum_q < -ilim_pos) begin
			integ_clamped = INTEG_W'(-ilim_pos);
		end else begin
			integ_clamped = isum_q[INTEG_W-1:0];
		end

		// p term divided by 256, toward zero
		pbias  = prod_q + $signed(PROD_W'({8{prod_q[PROD_W-1]}}));
		pshift = pbias >>> 8;

		ptl = $signed(PRAW_W'(cfg.p_term_limit));
		if (praw_q > ptl) begin
			p_d = ptl[15:0];
		end else if (praw_q < -ptl) begin
			p_d = 16'(-ptl);
		end else begin
			p_d = praw_q[15:0];
		end

		// integrator integer part, toward zero
		ibias  = integ_q + $signed(INTEG_W'({16{integ_q[INTEG_W-1]}}));
		ishift = ibias >>> 16;

		lim_o  = $signed(18'(cfg.adjust_limit));
		sat_hi = 1'b0;
		sat_lo = 1'b0;
		if (osum_q > lim_o) begin
			outv   = lim_o;
			sat_hi = 1'b1;
		end else if (osum_q < -lim_o) begin
			outv   = -lim_o;
			sat_lo = 1'b1;
		end else begin
			outv = osum_q;
		end
		windup = 17'(outv) - 17'(p_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
			avg_q    <= '0;
			integ_q  <= '0;
		end else begin
			case (ctl.op)
				OP_FIRST: begin
					avg_q    <= {level_q, 16'b0};
					loaded_q <= 1'b1;
				end
				OP_AVG_FIN: avg_q   <= acc_q + AVG_W'(prod_q[PROD_W-1:16]);
				OP_ICLAMP:  integ_q <= integ_clamped;
				OP_EMIT: begin
					// anti-windup when the output saturates against the error
					if ((sat_hi && err_q < 0) || (sat_lo && err_q > 0)) begin
						integ_q <= {windup, 16'b0};
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		case (ctl.op)
			OP_LOAD:    level_q <= LEVEL_W'(CNT_W'(fifo_count)) + LEVEL_W'(CNT_W'(pend_count));
			OP_ACC_SET: acc_q   <= AVG_W'(prod_q);
			OP_ACC_ADD: acc_q   <= acc_q + AVG_W'(prod_q);
			OP_ERR:     err_q   <= err_d;
			OP_ECLAMP:  e_q     <= e_d;
			OP_ISUM:    isum_q  <= ISUM_W'(integ_q) + ISUM_W'(prod_q);
			OP_ICLAMP:  praw_q  <= pshift[PRAW_W-1:0];
			OP_PCLAMP: begin
				p_q   <= p_d;
				itr_q <= ishift[16:0];
			end
			OP_OSUM:    osum_q  <= 18'(p_q) + 18'(itr_q);
			OP_EMIT: begin
				rate_adjust_q <= outv[15:0];
				smoothed_q    <= 17'(floored);
				level_error_q <= err_q;
			end
			default: ;
		endcase
	end

	assign status.loaded  = loaded_q;
	assign rate_adjust    = rate_adjust_q;
	assign smoothed_level = smoothed_q;
	assign level_error    = level_error_q;

endmodule

>>> rtl/core/buffer_level_pi_rate_controller.sv
// top level of the buffer level pi rate controller: configuration registers and the two units
// depends on blprc_pkg, blprc_sequencer and blprc_datapath
//
// Each accepted word (fifo and pending byte counts) gives one result word: the rate correction,
// the integer moving-average level and the level error. The control program steps each word
// through its operations, one operation per cycle through a single shared 18x21 multiplier
// while no handshake holds it; the first word after reset loads the average directly and
// skips the averaging steps. A new word is taken only in the idle step, once the last result
// has gone to the output register, where it may still wait while the next word is taken.
// Configuration writes are always accepted; indexes past the last register are ignored.
module buffer_level_pi_rate_controller #(
	parameter int COUNT_BITS = blprc_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [blprc_pkg::IN_W-1:0]          fifo_count,
	input  logic [blprc_pkg::IN_W-1:0]          pend_count,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [15:0]                  rate_adjust,
	output logic [16:0]                         smoothed_level,
	output logic signed [blprc_pkg::ERR_W-1:0]  level_error,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [blprc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [blprc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import blprc_pkg::*;

	cfg_t       cfg_q;
	dp_ctl_t    ctl;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_level    <= RST_TARGET_LEVEL;
			cfg_q.smoothing_alpha <= RST_SMOOTHING;
			cfg_q.p_gain          <= RST_P_GAIN;
			cfg_q.i_gain          <= RST_I_GAIN;
			cfg_q.adjust_limit    <= RST_ADJUST_LIMIT;
			cfg_q.p_term_limit    <= RST_P_TERM_LIMIT;
			cfg_q.integral_limit  <= RST_INTEGRAL_LIMIT;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TARGET_LEVEL:   cfg_q.target_level    <= cfg_data[16:0];
				REG_SMOOTHING:      cfg_q.smoothing_alpha <= cfg_data[16:0];
				REG_P_GAIN:         cfg_q.p_gain          <= cfg_data[15:0];
				REG_I_GAIN:         cfg_q.i_gain          <= cfg_data;
				REG_ADJUST_LIMIT:   cfg_q.adjust_limit    <= cfg_data[14:0];
				REG_P_TERM_LIMIT:   cfg_q.p_term_limit    <= cfg_data[14:0];
				REG_INTEGRAL_LIMIT: cfg_q.integral_limit  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	blprc_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.ctl       (ctl)
	);

	blprc_datapath #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.status         (status),
		.cfg            (cfg_q),
		.fifo_count     (fifo_count),
		.pend_count     (pend_count),
		.rate_adjust    (rate_adjust),
		.smoothed_level (smoothed_level),
		.level_error    (level_error)
	);

endmodule

>>> verif/tb_top.sv
// self-checking testbench for buffer_level_pi_rate_controller: directed rows, then random phases
// with random register settings, every result word checked against an in-bench fixed-point model
// depends on blprc_pkg and buffer_level_pi_rate_controller
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import blprc_pkg::*;

	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_WORDS = 1320;
	localparam int PLAN_LEN     = 32;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	typedef struct packed {
		logic signed [15:0]      rate_adjust;
		logic [16:0]             smoothed_level;
		logic signed [ERR_W-1:0] level_error;
	} rate_word_t;

	typedef enum logic {
		ROW_WORD,
		ROW_REG
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [19:0] a;
		logic [19:0] b;
		logic        typed;
		rate_word_t  want;
	} stim_row_t;

	// word rows: a = fifo bytes, b = pending bytes; register rows: a = index, b = data
	localparam stim_row_t PLAN [PLAN_LEN] = '{
		'{ROW_WORD, 20'h00000, 20'h00000, 1'b1, '{16'sd540, 17'd0, 18'sd4096}},
		'{ROW_WORD, 20'h0FFFF, 20'h0FFFF, 1'b0, '0},
		'{ROW_WORD, 20'h0FFFF, 20'h00000, 1'b0, '0},
		'{ROW_WORD, 20'h00000, 20'h0FFFF, 1'b0, '0},
		'{ROW_WORD, 20'h05555, 20'h0AAAA, 1'b0, '0},
		'{ROW_WORD, 20'h0AAAA, 20'h05555, 1'b0, '0},
		'{ROW_REG,  20'(REG_SMOOTHING),      20'hFFFFF, 1'b0, '0},
		'{ROW_REG,  20'(REG_ADJUST_LIMIT),   20'd100,   1'b0, '0},
		'{ROW_REG,  20'(REG_P_TERM_LIMIT),   20'h07FFF, 1'b0, '0},
		'{ROW_REG,  20'(REG_INTEGRAL_LIMIT), 20'h07FFF, 1'b0, '0},
		'{ROW_REG,  20'(REG_P_GAIN),         20'h0FFFF, 1'b0, '0},
		'{ROW_REG,  20'(REG_I_GAIN),         20'hFFFFF, 1'b0, '0},
		'{ROW_REG,  20'(REG_TARGET_LEVEL),   20'h1FFFF, 1'b0, '0},
		'{ROW_WORD, 20'h00000, 20'h00000, 1'b0, '0},
		'{ROW_WORD, 20'h00000, 20'h00000, 1'b0, '0},
		'{ROW_REG,  20'(REG_I_GAIN),         20'h00000, 1'b0, '0},
		'{ROW_REG,  20'(REG_P_GAIN),         20'h00000, 1'b0, '0},
		'{ROW_REG,  20'(REG_TARGET_LEVEL),   20'h00000, 1'b0, '0},
		// integrator wound up high, error negative: anti-windup from the top
		'{ROW_WORD, 20'd1000,  20'h00000, 1'b0, '0},
		'{ROW_REG,  20'(REG_I_GAIN),         20'hFFFFF, 1'b0, '0},
		'{ROW_WORD, 20'h0FFFF, 20'h0FFFF, 1'b0, '0},
		'{ROW_REG,  20'(REG_I_GAIN),         20'h00000, 1'b0, '0},
		'{ROW_REG,  20'(REG_TARGET_LEVEL),   20'h1FFFF, 1'b0, '0},
		// integrator wound up low, error positive: anti-windup from the bottom
		'{ROW_WORD, 20'h00000, 20'h00000, 1'b0, '0},
		'{ROW_REG,  20'(REG_ADJUST_LIMIT),   20'h00000, 1'b0, '0},
		'{ROW_WORD, 20'h01234, 20'h00FED, 1'b0, '0},
		'{ROW_REG,  20'(REG_SMOOTHING),      20'h00000, 1'b0, '0},
		'{ROW_WORD, 20'h0FFFF, 20'h0FFFF, 1'b0, '0},
		'{ROW_REG,  20'(REG_UNMAPPED),       20'hFFFFF, 1'b0, '0},
		'{ROW_REG,  20'(REG_SMOOTHING),      20'd65536, 1'b0, '0},
		'{ROW_WORD, 20'h000FF, 20'h0FF00, 1'b0, '0},
		'{ROW_WORD, 20'h0FF00, 20'h000FF, 1'b0, '0}
	};

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    in_valid      = 1'b0;
	logic                    in_ready;
	logic [IN_W-1:0]         fifo_count    = '0;
	logic [IN_W-1:0]         pend_count    = '0;
	logic                    out_valid;
	logic                    out_ready     = 1'b0;
	logic signed [15:0]      rate_adjust;
	logic [16:0]             smoothed_level;
	logic signed [ERR_W-1:0] level_error;
	logic                    cfg_valid     = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index     = '0;
	logic [CFG_DATA_W-1:0]   cfg_data      = '0;

	cfg_t ctl_cfg = '{target_level: RST_TARGET_LEVEL, smoothing_alpha: RST_SMOOTHING,
		p_gain: RST_P_GAIN, i_gain: RST_I_GAIN, adjust_limit: RST_ADJUST_LIMIT,
		p_term_limit: RST_P_TERM_LIMIT, integral_limit: RST_INTEGRAL_LIMIT};
	longint avg_q16    = 0;
	bit     avg_loaded = 1'b0;
	longint integ_q16  = 0;

	rate_word_t expected_words[$];
	int fault_count  = 0;
	int results_seen = 0;
	int burst_left   = 0;

	buffer_level_pi_rate_controller dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp_sym(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic rate_word_t next_rate_word(logic [IN_W-1:0] fifo, logic [IN_W-1:0] pend);
		longint lvl, alpha, floored, err, lim, p_term, out_v;
		rate_word_t r;
		lvl = longint'(fifo) + longint'(pend);
		alpha = (ctl_cfg.smoothing_alpha > ONE_Q16) ? longint'(ONE_Q16)
			: longint'(ctl_cfg.smoothing_alpha);
		if (!avg_loaded) begin
			avg_q16 = lvl * 65536;
			avg_loaded = 1'b1;
		end else begin
			avg_q16 = (alpha * lvl * 65536 + (65536 - alpha) * avg_q16) / 65536;
		end
		floored = avg_q16 / 65536;
		err = longint'(ctl_cfg.target_level) - floored;
		lim = longint'(ctl_cfg.adjust_limit);
		p_term = clamp_sym(clamp_sym(err, lim) * longint'(ctl_cfg.p_gain) / 256,
			longint'(ctl_cfg.p_term_limit));
		integ_q16 = clamp_sym(integ_q16 + err * longint'(ctl_cfg.i_gain),
			longint'(ctl_cfg.integral_limit) * 65536);
		out_v = p_term + integ_q16 / 65536;
		if (out_v > lim) begin
			out_v = lim;
			if (err < 0)
				integ_q16 = (out_v - p_term) * 65536;
		end else if (out_v < -lim) begin
			out_v = -lim;
			if (err > 0)
				integ_q16 = (out_v - p_term) * 65536;
		end
		r.rate_adjust = out_v[15:0];
		r.smoothed_level = floored[16:0];
		r.level_error = err[ERR_W-1:0];
		return r;
	endfunction

	function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_TARGET_LEVEL:   ctl_cfg.target_level = d[16:0];
			REG_SMOOTHING:      ctl_cfg.smoothing_alpha = d[16:0];
			REG_P_GAIN:         ctl_cfg.p_gain = d[15:0];
			REG_I_GAIN:         ctl_cfg.i_gain = d[19:0];
			REG_ADJUST_LIMIT:   ctl_cfg.adjust_limit = d[14:0];
			REG_P_TERM_LIMIT:   ctl_cfg.p_term_limit = d[14:0];
			REG_INTEGRAL_LIMIT: ctl_cfg.integral_limit = d[14:0];
			default: ;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_reg_value(int unsigned typical_max);
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return CFG_DATA_W'($urandom);
			default: return CFG_DATA_W'($urandom_range(0, typical_max));
		endcase
	endfunction

	function automatic logic [IN_W-1:0] near_level(int unsigned center);
		int v;
		v = int'(center) + int'($urandom_range(0, 1024)) - 512;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[IN_W-1:0];
	endfunction

	task automatic send_word(logic [IN_W-1:0] f, logic [IN_W-1:0] p);
		in_valid <= 1'b1;
		cfg_valid <= 1'b0;
		fifo_count <= f;
		pend_count <= p;
		do @(posedge clk); while (!in_ready);
		expected_words.push_back(next_rate_word(f, p));
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		set_reg(idx, d);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	// bursts of back-to-back words with random gaps between them
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24);
			if (gap != 0) begin
				in_valid <= 1'b0;
				cfg_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 60);
		end
		burst_left--;
	endtask

	task automatic send_random_word();
		int unsigned center;
		logic [IN_W-1:0] f, p;
		center = ctl_cfg.target_level / 2;
		case ($urandom_range(0, 9))
			0, 1: begin
				f = IN_W'($urandom);
				p = IN_W'($urandom);
			end
			2: begin
				f = $urandom_range(0, 1) ? '1 : '0;
				p = $urandom_range(0, 1) ? '1 : '0;
			end
			3: begin
				f = IN_W'($urandom_range(0, 255));
				p = IN_W'($urandom_range(0, 255));
			end
			default: begin
				f = near_level(center);
				p = near_level(center);
			end
		endcase
		pace_sender();
		send_word(f, p);
	endtask

	// receiver stalls, plus long hold-offs that back the block up into its input
	initial begin : receiver
		int next_hold;
		int n;
		next_hold = 250;
		forever begin
			if (results_seen >= next_hold) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				next_hold += 650;
			end
			case ($urandom_range(0, 3))
				0: begin
					out_ready <= 1'b1;
					n = $urandom_range(20, 80);
				end
				1: begin
					out_ready <= 1'b0;
					n = $urandom_range(1, 12);
				end
				default: begin
					out_ready <= 1'b1;
					n = $urandom_range(1, 6);
				end
			endcase
			repeat (n) @(posedge clk);
		end
	end

	always @(posedge clk) begin : check_results
		rate_word_t want;
		if (out_valid && out_ready) begin
			results_seen++;
			if (expected_words.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result word: rate %0d level %0d error %0d",
						rate_adjust, smoothed_level, level_error);
			end else begin
				want = expected_words.pop_front();
				if (want.rate_adjust !== rate_adjust || want.smoothed_level !== smoothed_level
						|| want.level_error !== level_error) begin
					fault_count++;
					if (fault_count <= 10)
						$display("result %0d: expected %0d %0d %0d, got %0d %0d %0d",
							results_seen, want.rate_adjust, want.smoothed_level,
							want.level_error, rate_adjust, smoothed_level, level_error);
				end
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		stim_row_t row;
		int random_sent;
		int phase_words;
		random_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_LEN; i++) begin
			row = PLAN[i];
			if (row.kind == ROW_REG) begin
				drain();
				write_reg(row.a[CFG_IDX_W-1:0], row.b[CFG_DATA_W-1:0]);
			end else begin
				pace_sender();
				send_word(row.a[IN_W-1:0], row.b[IN_W-1:0]);
				if (row.typed)
					expected_words[expected_words.size()-1] = row.want;
			end
		end

		while (random_sent < RANDOM_WORDS) begin
			drain();
			write_reg(REG_TARGET_LEVEL, pick_reg_value(20000));
			write_reg(REG_SMOOTHING, pick_reg_value(65536));
			write_reg(REG_P_GAIN, pick_reg_value(1024));
			write_reg(REG_I_GAIN, pick_reg_value(8192));
			write_reg(REG_ADJUST_LIMIT, pick_reg_value(4000));
			write_reg(REG_P_TERM_LIMIT, pick_reg_value(2000));
			write_reg(REG_INTEGRAL_LIMIT, pick_reg_value(2000));
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
			phase_words = $urandom_range(60, 140);
			repeat (phase_words) send_random_word();
			random_sent += phase_words;
		end

		drain();
		repeat (24) @(posedge clk);
		if (fault_count == 0 && expected_words.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/blprc_pkg.sv
rtl/core/blprc_sequencer.sv
rtl/core/blprc_datapath.sv
rtl/core/buffer_level_pi_rate_controller.sv
verif/tb_top.sv
